>>> hw/rtl/positional_list_store_assert.svh
// Assertion macros used by the list store RTL.
`ifndef POSITIONAL_LIST_STORE_ASSERT_SVH
`define POSITIONAL_LIST_STORE_ASSERT_SVH

// Checks that an expression holds at every rising clock edge outside reset.
`define PLS_ASSERT_ALWAYS(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error("list store assertion failed");

// Checks that a condition in one cycle implies another in the next cycle.
`define PLS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("list store assertion failed");

`endif

>>> hw/rtl/pls_pkg.sv
// Package with the command codes, status codes and request types of the list store.
package pls_pkg;

  // Default number of entries in the store.
  localparam int CAPACITY_DEF = 16;

  // Command codes.
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd0;
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [2:0] CMD_INSERT     = 3'd2;
  localparam logic [2:0] CMD_ERASE      = 3'd3;
  localparam logic [2:0] CMD_READ       = 3'd4;

  // Status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  // One command as it enters the store.
  typedef struct packed {
    logic [2:0]         cmd;
    logic [7:0]         position;
    logic signed [31:0] value;
  } req_t;

  // One result as it leaves the store.
  typedef struct packed {
    logic signed [31:0] read_value;
    logic [8:0]         count;
    logic [1:0]         status;
  } rsp_t;

endpackage

>>> hw/rtl/pls_in_if.sv
// Command channel interface of the list store.
interface pls_in_if;
  import pls_pkg::*;

  logic               valid;
  logic               ready;
  logic [2:0]         cmd;
  logic [7:0]         position;
  logic signed [31:0] value;

  modport source (output valid, output cmd, output position, output value, input ready);
  modport sink   (input valid, input cmd, input position, input value, output ready);
endinterface

>>> hw/rtl/pls_out_if.sv
// Result channel interface of the list store.
interface pls_out_if;
  import pls_pkg::*;

  logic               valid;
  logic               ready;
  logic signed [31:0] read_value;
  logic [8:0]         count;
  logic [1:0]         status;

  modport source (output valid, output read_value, output count, output status, input ready);
  modport sink   (input valid, input read_value, input count, input status, output ready);
endinterface

>>> hw/rtl/pls_store.sv
// Register array of list elements with the shift logic for one command per cycle while enabled.
`include "positional_list_store_assert.svh"

module pls_store #(
  parameter int CAPACITY = pls_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  pls_pkg::req_t req,
  output pls_pkg::rsp_t rsp
);
  import pls_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic signed [31:0] elem_r [CAPACITY];
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   cnt_nxt;

  logic [8:0] cnt9;
  logic [8:0] pos9;
  logic       full;
  logic       pos_ok;
  logic       shift_up;
  logic       shift_down;
  logic       append;
  logic [8:0] split;

  assign cnt9   = 9'(cnt_r);
  assign pos9   = {1'b0, req.position};
  assign full   = (cnt_r == CNT_W'(CAPACITY));
  assign pos_ok = (pos9 < cnt9);

  // Decode the command into array moves, the count update and the result.
  always_comb begin
    shift_up       = 1'b0;
    shift_down     = 1'b0;
    append         = 1'b0;
    split          = pos9;
    cnt_nxt        = cnt_r;
    rsp.read_value = '0;
    rsp.status     = ST_OK;
    unique case (req.cmd)
      CMD_PUSH_BACK: begin
        if (full) begin
          rsp.status = ST_FULL;
        end else begin
          append  = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      CMD_PUSH_FRONT: begin
        split = '0;
        if (full) begin
          rsp.status = ST_FULL;
        end else begin
          shift_up = 1'b1;
          cnt_nxt  = cnt_r + 1'b1;
        end
      end
      CMD_INSERT: begin
        if (!pos_ok) begin
          rsp.status = ST_BADPOS;
        end else if (full) begin
          rsp.status = ST_FULL;
        end else begin
          shift_up = 1'b1;
          cnt_nxt  = cnt_r + 1'b1;
        end
      end
      CMD_ERASE: begin
        if (!pos_ok) begin
          rsp.status = ST_BADPOS;
        end else begin
          shift_down = 1'b1;
          cnt_nxt    = cnt_r - 1'b1;
        end
      end
      CMD_READ: begin
        if (!pos_ok) begin
          rsp.read_value = -32'sd1;
          rsp.status     = ST_BADPOS;
        end else begin
          rsp.read_value = elem_r[req.position[IDX_W-1:0]];
        end
      end
      default: begin
      end
    endcase
    rsp.count = 9'(cnt_nxt);
  end

  // Each entry takes the new value, its lower neighbor or its upper neighbor, or holds.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_entry
    localparam logic [8:0] IDX = 9'(i);
    always_ff @(posedge clk) begin
      if (en) begin
        if (shift_up && IDX >= split) begin
          if (IDX == split) begin
            elem_r[i] <= req.value;
          end else begin
            elem_r[i] <= elem_r[(i > 0) ? i - 1 : 0];
          end
        end else if (append && IDX == cnt9) begin
          elem_r[i] <= req.value;
        end else if (shift_down && IDX >= split && i < CAPACITY - 1) begin
          elem_r[i] <= elem_r[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
    end
  end

  // Element count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (en) begin
      cnt_r <= cnt_nxt;
    end
  end

  `PLS_ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, cnt_r <= CNT_W'(CAPACITY))
  `PLS_ASSERT_NEXT(a_full_holds, clk, rst_n, en && rsp.status == ST_FULL, $stable(cnt_r))
  `PLS_ASSERT_NEXT(a_push_grows, clk, rst_n,
    en && rsp.status == ST_OK && (req.cmd == CMD_PUSH_BACK || req.cmd == CMD_PUSH_FRONT),
    cnt_r == CNT_W'($past(cnt_r) + 1'b1))
  `PLS_ASSERT_NEXT(a_erase_shrinks, clk, rst_n,
    en && rsp.status == ST_OK && req.cmd == CMD_ERASE,
    cnt_r == CNT_W'($past(cnt_r) - 1'b1))

endmodule

>>> hw/rtl/positional_list_store.sv
// Top level of the list store: request register, element store and result register.
// An accepted request is held in the request register until the result register
// can take it. Throughput: one request per cycle while results are taken; the element
// array updates in the same cycle the request moves into the result register.
// The result register lets a new request in while a result waits to be taken.
// Reset clears the element count and both valid flags; element contents are not cleared.
module positional_list_store #(
  parameter int CAPACITY = pls_pkg::CAPACITY_DEF
) (
  input logic    clk,
  input logic    rst_n,
  pls_in_if.sink   in_ch,
  pls_out_if.source out_ch
);
  import pls_pkg::*;

  logic s1_valid_r;
  logic s1_valid_nxt;
  req_t s1_req_r;
  logic out_valid_r;
  logic out_valid_nxt;
  rsp_t out_rsp_r;
  rsp_t rsp;
  logic advance;
  logic take;

  // The request register moves on when the result register is free or is being emptied.
  // No request is taken while reset is held.
  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = rst_n && (!s1_valid_r || advance);
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt  = take ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
    out_valid_nxt = advance ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
  end

  // Valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (take) begin
      s1_req_r.cmd      <= in_ch.cmd;
      s1_req_r.position <= in_ch.position;
      s1_req_r.value    <= in_ch.value;
    end
    if (advance) begin
      out_rsp_r <= rsp;
    end
  end

  pls_store #(
    .CAPACITY(CAPACITY)
  ) u_store (
    .clk  (clk),
    .rst_n(rst_n),
    .en   (advance),
    .req  (s1_req_r),
    .rsp  (rsp)
  );

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_value = out_rsp_r.read_value;
  assign out_ch.count      = out_rsp_r.count;
  assign out_ch.status     = out_rsp_r.status;

endmodule

>>> tb/positional_list_store_test.sv
// Self-checking testbench for the positional list store: directed table, then random commands.
`timescale 1ns / 100ps

module positional_list_store_test;
  import pls_pkg::*;

  localparam int CAP = CAPACITY_DEF;
  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_SEGMENTS = 46;
  localparam int SEGMENT_LEN = 40;

  // Command codes the store ignores.
  localparam logic [2:0] CMD_SPARE_A = 3'd5;
  localparam logic [2:0] CMD_SPARE_B = 3'd6;
  localparam logic [2:0] CMD_SPARE_C = 3'd7;

  // Bias of the random command mix.
  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN} mix_t;

  // One line of the directed table; a fixed row carries its expected result.
  typedef struct {
    req_t        req;
    int unsigned reps;
    bit          fixed;
    rsp_t        rsp;
  } plan_row_t;

  logic clk;
  logic rst_n;

  pls_in_if  cmd_bus ();
  pls_out_if rsp_bus ();

  positional_list_store #(.CAPACITY(CAP)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (cmd_bus),
    .out_ch (rsp_bus)
  );

  // Shadow copy of the list and the expected results in order of request.
  logic signed [31:0] shadow_list [CAP];
  int unsigned        shadow_len;
  rsp_t               pending_rsp [$];
  plan_row_t          plan [$];
  int unsigned        err_count;
  int unsigned        cycle_count;
  bit                 quiet;

  // Clock.
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Apply one command to the shadow list and return the result it should give.
  function automatic rsp_t predict_list(input req_t r);
    rsp_t res;
    int   i;
    bit   full;
    bit   in_range;
    res.read_value = '0;
    res.status = ST_OK;
    full = (shadow_len >= CAP);
    in_range = (r.position < shadow_len);
    case (r.cmd)
      CMD_PUSH_BACK: begin
        if (full) begin
          res.status = ST_FULL;
        end else begin
          shadow_list[shadow_len] = r.value;
          shadow_len++;
        end
      end
      CMD_PUSH_FRONT: begin
        if (full) begin
          res.status = ST_FULL;
        end else begin
          for (i = shadow_len; i > 0; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[0] = r.value;
          shadow_len++;
        end
      end
      CMD_INSERT: begin
        if (!in_range) begin
          res.status = ST_BADPOS;
        end else if (full) begin
          res.status = ST_FULL;
        end else begin
          for (i = shadow_len; i > r.position; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[r.position] = r.value;
          shadow_len++;
        end
      end
      CMD_ERASE: begin
        if (!in_range) begin
          res.status = ST_BADPOS;
        end else begin
          for (i = r.position; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
          shadow_len--;
        end
      end
      CMD_READ: begin
        if (!in_range) begin
          res.read_value = -32'sd1;
          res.status = ST_BADPOS;
        end else begin
          res.read_value = shadow_list[r.position];
        end
      end
      default: begin
      end
    endcase
    res.count = shadow_len[8:0];
    return res;
  endfunction

  // Idle length: mostly none or short, now and then long; none in a quiet stretch.
  function automatic int idle_len();
    int pick;
    if (quiet) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Build a directed table line.
  function automatic plan_row_t plan_row(input logic [2:0] cmd, input logic [7:0] pos,
                                         input logic signed [31:0] val, input int unsigned reps,
                                         input bit fixed, input logic signed [31:0] rd,
                                         input logic [8:0] cnt, input logic [1:0] st);
    plan_row_t row;
    row.req.cmd = cmd;
    row.req.position = pos;
    row.req.value = val;
    row.reps = reps;
    row.fixed = fixed;
    row.rsp.read_value = rd;
    row.rsp.count = cnt;
    row.rsp.status = st;
    return row;
  endfunction

  // Append a line to the directed table.
  function automatic void add_row(input plan_row_t row);
    plan = {plan, row};
  endfunction

  // Random command, biased by the mix and aimed mostly at positions near the list.
  function automatic req_t random_req(input mix_t mix);
    req_t r;
    int   pick;
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      case ($urandom_range(0, 2))
        0: r.cmd = CMD_SPARE_A;
        1: r.cmd = CMD_SPARE_B;
        default: r.cmd = CMD_SPARE_C;
      endcase
    end else begin
      pick = $urandom_range(0, 99);
      case (mix)
        MIX_GROW: begin
          if (pick < 30) r.cmd = CMD_PUSH_BACK;
          else if (pick < 55) r.cmd = CMD_PUSH_FRONT;
          else if (pick < 80) r.cmd = CMD_INSERT;
          else if (pick < 93) r.cmd = CMD_READ;
          else r.cmd = CMD_ERASE;
        end
        MIX_SHRINK: begin
          if (pick < 50) r.cmd = CMD_ERASE;
          else if (pick < 75) r.cmd = CMD_READ;
          else if (pick < 82) r.cmd = CMD_PUSH_BACK;
          else if (pick < 89) r.cmd = CMD_PUSH_FRONT;
          else r.cmd = CMD_INSERT;
        end
        default: begin
          if (pick < 20) r.cmd = CMD_PUSH_BACK;
          else if (pick < 40) r.cmd = CMD_PUSH_FRONT;
          else if (pick < 60) r.cmd = CMD_INSERT;
          else if (pick < 80) r.cmd = CMD_ERASE;
          else r.cmd = CMD_READ;
        end
      endcase
    end
    pick = $urandom_range(0, 99);
    if (pick < 10 && shadow_len > 0) r.position = 8'(shadow_len - 1);
    else if (pick < 15) r.position = 8'(shadow_len);
    else if (pick < 80) r.position = 8'($urandom_range(0, shadow_len));
    else r.position = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 3) r.value = 32'sh8000_0000;
    else if (pick < 6) r.value = 32'sh7fff_ffff;
    else if (pick < 8) r.value = '0;
    else if (pick < 10) r.value = -32'sd1;
    else r.value = $urandom;
    return r;
  endfunction

  // Offer one request, wait for acceptance and record what it should return.
  task automatic send_command(input req_t r, input bit fixed, input rsp_t fixed_rsp);
    int   gap;
    rsp_t model_rsp;
    gap = idle_len();
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_bus.valid    <= 1'b1;
    cmd_bus.cmd      <= r.cmd;
    cmd_bus.position <= r.position;
    cmd_bus.value    <= r.value;
    @(posedge clk);
    while (!cmd_bus.ready) @(posedge clk);
    model_rsp = predict_list(r);
    pending_rsp = {pending_rsp, (fixed ? fixed_rsp : model_rsp)};
  endtask

  // Result side: random stalls with quiet stretches.
  initial begin : result_ready_gen
    int stall;
    rsp_bus.ready = 1'b0;
    @(posedge clk);
    forever begin
      stall = idle_len();
      if (stall > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_bus.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin : result_check
    rsp_t want;
    if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_rsp.size() == 0) begin
        $error("result with no request waiting: read_value %0d count %0d status %0d",
               rsp_bus.read_value, rsp_bus.count, rsp_bus.status);
        err_count++;
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_bus.read_value !== want.read_value) begin
          $error("read_value: expected %0d, got %0d", want.read_value, rsp_bus.read_value);
          err_count++;
        end
        if (rsp_bus.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, rsp_bus.count);
          err_count++;
        end
        if (rsp_bus.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
          err_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Stimulus: reset, directed table, random segments, then drain.
  initial begin : stimulus
    plan_row_t   row;
    req_t        r;
    mix_t        mix;
    int          seg;
    int          k;
    int unsigned n;
    err_count = 0;
    cycle_count = 0;
    quiet = 1'b0;
    shadow_len = 0;
    rst_n = 1'b0;
    cmd_bus.valid = 1'b0;
    cmd_bus.cmd = CMD_PUSH_BACK;
    cmd_bus.position = '0;
    cmd_bus.value = '0;

    // Empty store: every positional command is out of range.
    add_row(plan_row(CMD_READ, 8'd0, 32'sd0, 1, 1, -32'sd1, 9'd0, ST_BADPOS));
    add_row(plan_row(CMD_ERASE, 8'd0, 32'sd0, 1, 1, 32'sd0, 9'd0, ST_BADPOS));
    add_row(plan_row(CMD_INSERT, 8'd0, 32'sd5, 1, 1, 32'sd0, 9'd0, ST_BADPOS));
    // Extreme values at both ends.
    add_row(plan_row(CMD_PUSH_BACK, 8'd0, 32'sh7fff_ffff, 1, 1, 32'sd0, 9'd1, ST_OK));
    add_row(plan_row(CMD_PUSH_FRONT, 8'd255, 32'sh8000_0000, 1, 1, 32'sd0, 9'd2, ST_OK));
    add_row(plan_row(CMD_READ, 8'd0, 32'sd0, 1, 0, 32'sd0, 9'd0, ST_OK));
    add_row(plan_row(CMD_READ, 8'd1, 32'sd0, 1, 0, 32'sd0, 9'd0, ST_OK));
    // Insert at the front and in the middle.
    add_row(plan_row(CMD_INSERT, 8'd0, -32'sd1, 1, 0, 32'sd0, 9'd0, ST_OK));
    add_row(plan_row(CMD_INSERT, 8'd2, 32'sd0, 1, 0, 32'sd0, 9'd0, ST_OK));
    // Out of range read and insert at the count.
    add_row(plan_row(CMD_READ, 8'd255, 32'sd0, 1, 1, -32'sd1, 9'd4, ST_BADPOS));
    add_row(plan_row(CMD_INSERT, 8'd4, 32'sd9, 1, 1, 32'sd0, 9'd4, ST_BADPOS));
    // Unused command codes are ignored.
    add_row(plan_row(CMD_SPARE_A, 8'd255, -32'sd1, 1, 0, 32'sd0, 9'd0, ST_OK));
    add_row(plan_row(CMD_SPARE_B, 8'd0, 32'sd0, 1, 0, 32'sd0, 9'd0, ST_OK));
    add_row(plan_row(CMD_SPARE_C, 8'd1, 32'sd1, 1, 0, 32'sd0, 9'd0, ST_OK));
    // Erase the last and then the first element.
    add_row(plan_row(CMD_ERASE, 8'd3, 32'sd0, 1, 0, 32'sd0, 9'd0, ST_OK));
    add_row(plan_row(CMD_ERASE, 8'd0, 32'sd0, 1, 0, 32'sd0, 9'd0, ST_OK));
    // Fill the store, then hit it with every kind of add.
    add_row(plan_row(CMD_PUSH_BACK, 8'd0, 32'sh1000_0000, CAP - 2, 0,
                     32'sd0, 9'd0, ST_OK));
    add_row(plan_row(CMD_PUSH_BACK, 8'd0, 32'sd1, 1, 1, 32'sd0, 9'(CAP), ST_FULL));
    add_row(plan_row(CMD_PUSH_FRONT, 8'd0, 32'sd2, 1, 1, 32'sd0, 9'(CAP), ST_FULL));
    add_row(plan_row(CMD_INSERT, 8'd0, 32'sd3, 1, 1, 32'sd0, 9'(CAP), ST_FULL));
    add_row(plan_row(CMD_INSERT, 8'(CAP), 32'sd4, 1, 1, 32'sd0, 9'(CAP), ST_BADPOS));
    add_row(plan_row(CMD_READ, 8'(CAP - 1), 32'sd0, 1, 0, 32'sd0, 9'd0, ST_OK));
    add_row(plan_row(CMD_READ, 8'(CAP), 32'sd0, 1, 1, -32'sd1, 9'(CAP), ST_BADPOS));
    // Erase the last slot of a full store, refill from the front, then empty it.
    add_row(plan_row(CMD_ERASE, 8'(CAP - 1), 32'sd0, 1, 0, 32'sd0, 9'd0, ST_OK));
    add_row(plan_row(CMD_PUSH_FRONT, 8'd0, 32'sh5a5a_a5a5, 1, 0, 32'sd0, 9'd0, ST_OK));
    add_row(plan_row(CMD_READ, 8'd0, 32'sd0, 1, 0, 32'sd0, 9'd0, ST_OK));
    add_row(plan_row(CMD_ERASE, 8'd0, 32'sd0, CAP, 0, 32'sd0, 9'd0, ST_OK));
    add_row(plan_row(CMD_READ, 8'd0, 32'sd0, 1, 1, -32'sd1, 9'd0, ST_BADPOS));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table.
    foreach (plan[i]) begin
      row = plan[i];
      for (n = 0; n < row.reps; n++) begin
        r = row.req;
        r.value = row.req.value + n;
        send_command(r, row.fixed, row.rsp);
      end
    end

    // Random segments each pick growth, shrinkage or an even mix at random.
    for (seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
      mix = mix_t'($urandom_range(0, 2));
      quiet = ($urandom_range(0, 4) == 0);
      for (k = 0; k < SEGMENT_LEN; k++) begin
        r = random_req(mix);
        send_command(r, 1'b0, '0);
      end
    end
    quiet = 1'b0;
    cmd_bus.valid <= 1'b0;

    // Drain the results, then wait for anything stray.
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
